// File: src/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, types and helpers for the Life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // configuration register width, fixed by the register map
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned OROW_W = $clog2(MAX_HEIGHT);
  // input row runs up to two past the last row while the frame drains
  localparam int unsigned IROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int unsigned MAXW0 = (DIM_W > COL_W) ? DIM_W : COL_W;
  localparam int unsigned MAXW1 = (MAXW0 > IROW_W) ? MAXW0 : IROW_W;
  // common width for position compares, with headroom for +2
  localparam int unsigned CMP_W = MAXW1 + 2;

  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned SUM_BIRTH  = 3;
  localparam int unsigned SUM_KEEP   = 4;
  localparam int unsigned WIN_BITS   = 9;
  localparam int unsigned LINE_BITS  = 2;

  typedef logic [CMP_W-1:0] cmp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  function automatic cmp_t clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    cmp_t vx;
    cmp_t res;
    vx = cmp_t'(v);
    if (vx < cmp_t'(MIN_DIM)) begin
      res = cmp_t'(MIN_DIM);
    end else if (vx > cmp_t'(hi)) begin
      res = cmp_t'(hi);
    end else begin
      res = vx;
    end
    return res;
  endfunction

endpackage

// File: src/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/life_generation_stencil.sv
// ----------------------------------------------------------------------------
// life_generation_stencil
// One generation of Life (B3/S23) over a raster streamed one cell per beat,
// using a 2-bit line store RAM and a 3x3 window.
// Results: the result registers load at the edge that accepts the causing beat;
// results lag input by one row plus one cell.
// Throughput: one beat per cycle while in_stall_o is low; the line store is read one beat ahead.
// Reset: counters, window and output valid clear; line store is not cleared.
// ----------------------------------------------------------------------------
module life_generation_stencil
  import lgs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cell_alive_i,
  input  logic                 drain_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 next_alive_o,
  output logic                 on_border_o,
  output logic                 frame_end_o
);

  logic [DIM_W-1:0]     frame_width_q, frame_height_q;
  logic [WIN_BITS-1:0]  win_q, win_d;
  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [IROW_W-1:0]    in_row_q, in_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic [OROW_W-1:0]    out_row_q, out_row_d;
  logic                 byp_q, byp_d;
  logic [LINE_BITS-1:0] byp_data_q;
  logic                 out_vld_q, out_vld_d;
  logic                 next_q, border_q, last_q;

  logic [LINE_BITS-1:0] rd_data, wr_data;
  logic [COL_W-1:0]     rd_addr;

  cmp_t wdt, hgt;
  logic in_acc, adv, in_frame, cell_bit, top_bit, mid_bit, emit;
  logic center, border, next_val, last;
  logic [3:0] sum;
  cmp_t in_col_x, in_row_x, out_col_x, out_row_x, in_col_inc, out_col_inc;
  cmp_t in_col_n, in_row_n;
  cfg_reg_e cfg_reg;

  assign in_stall_o = out_vld_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign wdt = clamp_dim(frame_width_q, MAX_WIDTH);
  assign hgt = clamp_dim(frame_height_q, MAX_HEIGHT);

  assign in_col_x  = cmp_t'(in_col_q);
  assign in_row_x  = cmp_t'(in_row_q);
  assign out_col_x = cmp_t'(out_col_q);
  assign out_row_x = cmp_t'(out_row_q);

  assign in_frame = in_row_x < hgt;
  // a drain beat mid-frame is taken but changes nothing
  assign adv      = in_acc & ~(in_frame & drain_i);
  assign cell_bit = in_frame ? cell_alive_i : 1'b0;

  // line store word: bit 1 = upper row, bit 0 = middle row
  assign top_bit = byp_q ? byp_data_q[1] : rd_data[1];
  assign mid_bit = byp_q ? byp_data_q[0] : rd_data[0];
  assign wr_data = {mid_bit, cell_bit};

  assign win_d = {cell_bit, mid_bit, top_bit, win_q[WIN_BITS-1:3]};
  assign emit  = (in_row_x > cmp_t'(1)) ||
                 ((in_row_x == cmp_t'(1)) && (in_col_x >= cmp_t'(1)));

  // neighbourhood evaluation on the shifted window
  always_comb begin
    int c;
    int r;
    logic skip;
    center = win_d[4];
    border = (out_row_x == '0) || (out_row_x + cmp_t'(1) >= hgt) ||
             (out_col_x == '0) || (out_col_x + cmp_t'(1) >= wdt);
    sum = '0;
    for (c = 0; c < 3; c++) begin
      for (r = 0; r < 3; r++) begin
        skip = ((c == 0) && (out_col_x == cmp_t'(1))) ||
               ((c == 2) && (out_col_x + cmp_t'(2) == wdt)) ||
               ((r == 0) && (out_row_x == cmp_t'(1))) ||
               ((r == 2) && (out_row_x + cmp_t'(2) == hgt));
        if (!skip) begin
          sum = sum + 4'(win_d[3*c+r]);
        end
      end
    end
    if (border) begin
      next_val = center;
    end else if (sum == 4'(SUM_BIRTH)) begin
      next_val = 1'b1;
    end else if (sum == 4'(SUM_KEEP)) begin
      next_val = center;
    end else begin
      next_val = 1'b0;
    end
    last = (out_row_x + cmp_t'(1) >= hgt) && (out_col_x + cmp_t'(1) >= wdt);
  end

  // position counters
  always_comb begin
    in_col_inc  = in_col_x + cmp_t'(1);
    out_col_inc = out_col_x + cmp_t'(1);
    if (in_col_inc >= wdt) begin
      in_col_n = '0;
      in_row_n = in_row_x + cmp_t'(1);
    end else begin
      in_col_n = in_col_inc;
      in_row_n = in_row_x;
    end
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (adv) begin
      if (emit && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        in_col_d = in_col_n[COL_W-1:0];
        in_row_d = in_row_n[IROW_W-1:0];
        if (emit) begin
          if (out_col_inc >= wdt) begin
            out_col_d = '0;
            out_row_d = out_row_q + OROW_W'(1);
          end else begin
            out_col_d = out_col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  // read one beat ahead; forward when the next read hits the word just written
  assign rd_addr = in_col_d;
  assign byp_d   = adv && (in_col_d == in_col_q);

  assign out_vld_d = (adv && emit) ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  assign cfg_reg = cfg_reg_e'(cfg_idx_i);

  lgs_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (in_col_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(MAX_WIDTH);
      frame_height_q <= DIM_W'(MAX_HEIGHT);
      win_q          <= '0;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      byp_q          <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (adv) begin
        win_q <= win_d;
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      byp_q     <= byp_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byp_d) begin
      byp_data_q <= wr_data;
    end
    if (adv && emit) begin
      next_q   <= next_val;
      border_q <= border;
      last_q   <= last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign next_alive_o = next_q;
  assign on_border_o  = border_q;
  assign frame_end_o  = last_q;

endmodule
